// ===== design/bacw_pkg.sv =====
// Package with the constants and per-byte CRC/whitening functions of the serializer.
`timescale 1ns / 1ps

package bacw_pkg;

  // CRC-24 preset, one byte repeated three times.
  localparam logic [7:0] CrcInitByte = 8'hAA;
  localparam logic [23:0] CrcInit = {CrcInitByte, CrcInitByte, CrcInitByte};
  // CRC feedback taps applied to the low and middle bytes.
  localparam logic [7:0] CrcTapLow = 8'hDA;
  localparam logic [7:0] CrcTapMid = 8'h60;
  // Whitening LFSR feedback taps and the seed bit forced at packet start.
  localparam logic [7:0] LfsrTap = 8'h88;
  localparam logic [6:0] LfsrSeedBit = 7'h40;

  localparam int unsigned ChanW = 6;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  // Register indexes, taken from the word address.
  localparam logic RegChannel = 1'b0;

  // Number of CRC bytes that follow the last data byte.
  localparam logic [1:0] CrcBytes = 2'd3;

  // Result of whitening one byte: mask bits and the advanced LFSR.
  typedef struct packed {
    logic [7:0] mask;
    logic [6:0] lfsr;
  } whiten_t;

  // Feed one byte into the CRC, least significant bit first.
  function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] d);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       fb;
    b0 = crc[23:16];
    b1 = crc[15:8];
    b2 = crc[7:0];
    for (int k = 0; k < 8; k++) begin
      fb = b0[0] ^ d[k];
      b0 = {b1[0], b0[7:1]};
      b1 = {b2[0], b1[7:1]};
      b2 = {1'b0, b2[7:1]};
      if (fb) begin
        b2 = b2 ^ CrcTapLow;
        b1 = b1 ^ CrcTapMid;
      end
    end
    return {b0, b1, b2};
  endfunction

  // Run the whitening LFSR for eight bits.
  function automatic whiten_t lfsr_byte(input logic [6:0] lfsr);
    whiten_t    r;
    logic [6:0] l;
    logic [7:0] t;
    l = lfsr;
    r.mask = '0;
    for (int k = 0; k < 8; k++) begin
      r.mask[k] = l[0];
      t = {1'b0, l} ^ (l[0] ? LfsrTap : 8'h00);
      l = t[7:1];
    end
    r.lfsr = l;
    return r;
  endfunction

  // Swap a byte from memory bit order into wire order.
  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

// ===== design/bacw_if.sv =====
// Valid/ready stream interfaces for the input bytes and the result bytes.
`timescale 1ns / 1ps

interface bacw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bacw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_crc;
  logic       end_of_packet;

  modport source (output valid, output out_byte, output is_crc, output end_of_packet,
                  input ready);
  modport sink (input valid, input out_byte, input is_crc, input end_of_packet,
                output ready);
endinterface

// ===== design/bacw_apb_regs.sv =====
// APB register file holding the channel number.
`timescale 1ns / 1ps

module bacw_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bacw_pkg::PaddrW-1:0]  paddr,
  input  logic [bacw_pkg::PdataW-1:0]  pwdata,
  output logic [bacw_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output logic [bacw_pkg::ChanW-1:0]   channel_o
);

  logic [bacw_pkg::ChanW-1:0] channel_q;
  logic                       wr_en;

  // A write completes in the access phase; the word address selects the register.
  assign wr_en = psel && penable && pwrite && (paddr[2] == bacw_pkg::RegChannel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= bacw_pkg::ChanW'(37);
    end else if (wr_en) begin
      channel_q <= pwdata[bacw_pkg::ChanW-1:0];
    end
  end

  // Read back the channel; other addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == bacw_pkg::RegChannel) begin
      prdata = {{(bacw_pkg::PdataW - bacw_pkg::ChanW){1'b0}}, channel_q};
    end
  end

  assign pready    = 1'b1;
  assign channel_o = channel_q;

endmodule

// ===== design/bacw_byte_path.sv =====
// Combinational byte step: CRC update, whitening and bit reversal of one byte.
`timescale 1ns / 1ps

module bacw_byte_path (
  input  logic [23:0] crc_i,
  input  logic [6:0]  lfsr_i,
  input  logic [7:0]  byte_i,
  input  logic        feed_i,
  output logic [7:0]  wire_byte_o,
  output logic [23:0] crc_o,
  output logic [6:0]  lfsr_o
);

  bacw_pkg::whiten_t wh;

  // Data bytes enter the CRC; CRC bytes only shift out of it.
  always_comb begin
    wh          = bacw_pkg::lfsr_byte(lfsr_i);
    lfsr_o      = wh.lfsr;
    wire_byte_o = bacw_pkg::bit_rev8(byte_i ^ wh.mask);
    if (feed_i) begin
      crc_o = bacw_pkg::crc_feed(crc_i, byte_i);
    end else begin
      crc_o = {crc_i[15:0], 8'h00};
    end
  end

endmodule

// ===== design/ble_adv_crc_whiten_serializer.sv =====
// Top level of the BLE advertising CRC-24 and whitening serializer.
`timescale 1ns / 1ps

// Usage:
// Packet bytes arrive on in_i (valid/ready), one byte per request, header first,
// with last_byte set on the final payload byte. Each byte leaves on out_o whitened
// and bit-reversed; after the last byte the three CRC bytes follow with is_crc set,
// and the third one carries end_of_packet.
// A result is in the output register the cycle after its input request or CRC
// step. With a ready receiver one byte per cycle flows; after a last byte the
// single output register emits one CRC byte per cycle while the receiver is ready,
// and input is held off meanwhile.
// The channel number is written through the APB port and seeds the whitening
// LFSR at the first byte of each packet; a write in the middle of a packet acts
// from the next packet on.
// Reset clears the output valid bit and arms packet start, so the first byte
// reloads the CRC with 0xAAAAAA and the LFSR with the channel number, bit 6 set;
// the channel resets to 37.
// When the receiver stalls, the output register holds its byte; a new request can
// still be taken in the cycle the held byte is taken, unless CRC bytes are pending.

module ble_adv_crc_whiten_serializer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bacw_in_if.sink                      in_i,
  bacw_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bacw_pkg::PaddrW-1:0]  paddr,
  input  logic [bacw_pkg::PdataW-1:0]  pwdata,
  output logic [bacw_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);

  logic [bacw_pkg::ChanW-1:0] channel;
  logic [23:0] crc_q, crc_d;
  logic [6:0]  lfsr_q, lfsr_d;
  logic        start_q, start_d;
  logic [1:0]  crc_left_q, crc_left_d;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        is_crc_q, eop_q;

  logic        out_free, in_fire, crc_step, gen_valid;
  logic [23:0] path_crc_in;
  logic [6:0]  path_lfsr_in;
  logic [7:0]  path_byte;
  logic [7:0]  path_wire;
  logic [23:0] path_crc_out;
  logic [6:0]  path_lfsr_out;

  bacw_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .channel_o (channel)
  );

  // Handshake: input is taken when the output slot frees and no CRC is pending.
  assign out_free  = !out_valid_q || out_o.ready;
  assign crc_step  = (crc_left_q != 2'd0) && out_free;
  assign in_i.ready = (crc_left_q == 2'd0) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign gen_valid = crc_step || in_fire;

  // Select the byte and register values for the shared byte path.
  always_comb begin
    if (crc_left_q != 2'd0) begin
      path_crc_in  = crc_q;
      path_lfsr_in = lfsr_q;
      path_byte    = crc_q[23:16];
    end else if (start_q) begin
      path_crc_in  = bacw_pkg::CrcInit;
      path_lfsr_in = {1'b0, channel} | bacw_pkg::LfsrSeedBit;
      path_byte    = in_i.data_byte;
    end else begin
      path_crc_in  = crc_q;
      path_lfsr_in = lfsr_q;
      path_byte    = in_i.data_byte;
    end
  end

  bacw_byte_path u_path (
    .crc_i       (path_crc_in),
    .lfsr_i      (path_lfsr_in),
    .byte_i      (path_byte),
    .feed_i      (crc_left_q == 2'd0),
    .wire_byte_o (path_wire),
    .crc_o       (path_crc_out),
    .lfsr_o      (path_lfsr_out)
  );

  // Next state of the CRC, LFSR and packet sequencing.
  always_comb begin
    crc_d      = crc_q;
    lfsr_d     = lfsr_q;
    start_d    = start_q;
    crc_left_d = crc_left_q;
    if (crc_step) begin
      crc_d      = path_crc_out;
      lfsr_d     = path_lfsr_out;
      crc_left_d = crc_left_q - 2'd1;
      if (crc_left_q == 2'd1) begin
        start_d = 1'b1;
      end
    end else if (in_fire) begin
      crc_d   = path_crc_out;
      lfsr_d  = path_lfsr_out;
      start_d = 1'b0;
      if (in_i.last_byte) begin
        crc_left_d = bacw_pkg::CrcBytes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= bacw_pkg::CrcInit;
      lfsr_q     <= bacw_pkg::LfsrSeedBit;
      start_q    <= 1'b1;
      crc_left_q <= 2'd0;
    end else begin
      crc_q      <= crc_d;
      lfsr_q     <= lfsr_d;
      start_q    <= start_d;
      crc_left_q <= crc_left_d;
    end
  end

  // Output register: valid bit with reset, payload loaded with each new result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= gen_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_valid) begin
      out_byte_q <= path_wire;
      is_crc_q   <= (crc_left_q != 2'd0);
      eop_q      <= (crc_left_q == 2'd1);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.is_crc        = is_crc_q;
  assign out_o.end_of_packet = eop_q;

  // The end mark only ever sits on a CRC byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.end_of_packet) |-> out_o.is_crc)
    else $error("end of packet on a non-CRC byte");

  // A last byte blocks input while its CRC bytes go out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_byte) |=> (!in_i.ready && crc_left_q == bacw_pkg::CrcBytes))
    else $error("input taken while CRC bytes are pending");

  // Emitting the final CRC byte arms the next packet start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (crc_step && crc_left_q == 2'd1) |=> start_q)
    else $error("packet start not armed after the CRC");

  // Input is never taken in the middle of a CRC run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (crc_left_q == 2'd0))
    else $error("input accepted during CRC emission");

endmodule
